// File: src/qrv_pkg.sv
`default_nettype none

package qrv_pkg;

   // Fixed-point format of the quaternion and vector fields
   localparam int FRAC_BITS = 14;
   localparam int VEC_WIDTH = 16;
   localparam int QW        = FRAC_BITS + 2;
   localparam int OUT_W     = 20;

   // Register map
   localparam int NUM_REGS = 4;
   localparam int ADDR_W   = $clog2(4 * NUM_REGS);
   localparam int DATA_W   = 32;

   // Datapath widths
   localparam int SQ_W  = 2 * QW;                  // q component squared
   localparam int MV_W  = QW + VEC_WIDTH;          // q component times v component
   localparam int A_W   = 2 * QW + 2;              // w^2 - |u|^2
   localparam int D_W   = MV_W + 3;                // 2 (u.v)
   localparam int C_W   = MV_W + 1;                // u x v
   localparam int W2_W  = QW + 1;                  // 2 w
   localparam int PA_W  = A_W + VEC_WIDTH;
   localparam int PD_W  = D_W + QW;
   localparam int PC_W  = W2_W + C_W;
   localparam int ACC_W = PD_W + 2;

   localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
   localparam int OUT_MIN = -(2 ** (OUT_W - 1));

   typedef logic signed [QW-1:0]        qcomp_type;
   typedef logic signed [VEC_WIDTH-1:0] vec_type;
   typedef logic signed [OUT_W-1:0]     out_type;

   typedef struct packed {
      qcomp_type x;
      qcomp_type y;
      qcomp_type z;
      qcomp_type w;
   } rot_type;

   typedef enum logic [1:0] {
      REG_X = 2'd0,
      REG_Y = 2'd1,
      REG_Z = 2'd2,
      REG_W = 2'd3
   } reg_idx_type;

   localparam qcomp_type ROT_W_RESET = QW'(2 ** FRAC_BITS);

endpackage

`default_nettype wire

// File: src/qrv_if.sv
`default_nettype none

interface qrv_req_if;
   logic             valid;
   logic             ready;
   qrv_pkg::vec_type vec_x;
   qrv_pkg::vec_type vec_y;
   qrv_pkg::vec_type vec_z;

   modport source (output valid, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qrv_rsp_if;
   logic             valid;
   logic             ready;
   qrv_pkg::out_type out_x;
   qrv_pkg::out_type out_y;
   qrv_pkg::out_type out_z;
   logic             saturated;

   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

// File: src/qrv_csr.sv
`default_nettype none

module qrv_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [qrv_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [qrv_pkg::DATA_W-1:0]   pwdata,
   output      logic [qrv_pkg::DATA_W-1:0]   prdata,
   output      logic                         pready,
   output      qrv_pkg::rot_type             rot
);

   qrv_pkg::rot_type     rot_ff;
   qrv_pkg::rot_type     rot_in;
   qrv_pkg::reg_idx_type idx;
   qrv_pkg::qcomp_type   wval;
   qrv_pkg::qcomp_type   rval;
   logic                 wr;

   assign pready = 1'b1;
   assign idx    = qrv_pkg::reg_idx_type'(paddr[qrv_pkg::ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite && pready;
   assign wval   = pwdata[qrv_pkg::QW-1:0];

   always_comb begin
      rot_in = rot_ff;
      if (wr) begin
         unique case (idx)
            qrv_pkg::REG_X: rot_in.x = wval;
            qrv_pkg::REG_Y: rot_in.y = wval;
            qrv_pkg::REG_Z: rot_in.z = wval;
            qrv_pkg::REG_W: rot_in.w = wval;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff.x <= '0;
         rot_ff.y <= '0;
         rot_ff.z <= '0;
         rot_ff.w <= qrv_pkg::ROT_W_RESET;
      end else begin
         rot_ff <= rot_in;
      end
   end

   always_comb begin
      unique case (idx)
         qrv_pkg::REG_X: rval = rot_ff.x;
         qrv_pkg::REG_Y: rval = rot_ff.y;
         qrv_pkg::REG_Z: rval = rot_ff.z;
         qrv_pkg::REG_W: rval = rot_ff.w;
      endcase
   end

   assign prdata = qrv_pkg::DATA_W'(rval);
   assign rot    = rot_ff;

   a_wr_w: assert property (@(posedge clock) disable iff (reset)
      wr && (idx == qrv_pkg::REG_W) |=> rot.w == $past(wval))
      else $error("rot_w write not taken");

   a_no_wr_hold: assert property (@(posedge clock) disable iff (reset)
      !wr |=> rot == $past(rot))
      else $error("rotation registers changed without a write");

   a_reset_identity: assert property (@(posedge clock)
      reset |=> rot.w == qrv_pkg::ROT_W_RESET && rot.x == '0)
      else $error("reset value wrong");

endmodule

`default_nettype wire

// File: src/quaternion_rotate_vector_unit.sv
`default_nettype none

// Rotates each request vector v by the programmed quaternion q as q*v*conj(q),
// without normalizing q, so a non-unit q also scales by |q|^2. Result is the
// exact product rescaled by 2^28 with round-half-up and clipped to signed
// 20 bits; saturated flags any clipped component. Throughput is one vector
// per clock while rsp accepts results. There are five register stages:
// squares/dot/cross products, their sums, the three scaled terms, the final
// sum, and the round/clip stage; rsp valid is the valid bit of the last
// stage. Each stage advances on its own, so bubbles are squeezed out when rsp
// stalls. Program rot_* over the APB port only while no request is in flight;
// reset gives identity.
module quaternion_rotate_vector_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   qrv_req_if.sink                         req_chan,
   qrv_rsp_if.source                       rsp_chan,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [qrv_pkg::ADDR_W-1:0] paddr,
   input  wire logic [qrv_pkg::DATA_W-1:0] pwdata,
   output      logic [qrv_pkg::DATA_W-1:0] prdata,
   output      logic                       pready
);

   localparam int NSTG  = 5;
   localparam int SHIFT = 2 * qrv_pkg::FRAC_BITS;
   localparam int ACC_W = qrv_pkg::ACC_W;

   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (SHIFT - 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(qrv_pkg::OUT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(qrv_pkg::OUT_MIN);

   qrv_pkg::rot_type rot;

   qrv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .rot     (rot)
   );

   qrv_pkg::qcomp_type qv [3];
   assign qv[0] = rot.x;
   assign qv[1] = rot.y;
   assign qv[2] = rot.z;

   // ---------------- stage control ----------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] v_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_chan.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_chan.valid : v_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = en[0];

   // ---------------- stage 1: first multiply layer ----------------
   logic signed [qrv_pkg::SQ_W-1:0] sq_ff  [4];
   logic signed [qrv_pkg::SQ_W-1:0] sq_in  [4];
   logic signed [qrv_pkg::MV_W-1:0] dot_ff [3];
   logic signed [qrv_pkg::MV_W-1:0] dot_in [3];
   logic signed [qrv_pkg::MV_W-1:0] crp_ff [6];
   logic signed [qrv_pkg::MV_W-1:0] crp_in [6];
   qrv_pkg::vec_type                vec1_ff [3];
   qrv_pkg::vec_type                vin [3];

   assign vin[0] = req_chan.vec_x;
   assign vin[1] = req_chan.vec_y;
   assign vin[2] = req_chan.vec_z;

   always_comb begin
      sq_in[0] = qrv_pkg::SQ_W'(rot.w) * qrv_pkg::SQ_W'(rot.w);
      for (int i = 0; i < 3; i++) begin
         sq_in[i+1] = qrv_pkg::SQ_W'(qv[i]) * qrv_pkg::SQ_W'(qv[i]);
         dot_in[i]  = qrv_pkg::MV_W'(qv[i]) * qrv_pkg::MV_W'(vin[i]);
      end
      // cross-product partials: (y vz, z vy), (z vx, x vz), (x vy, y vx)
      crp_in[0] = qrv_pkg::MV_W'(rot.y) * qrv_pkg::MV_W'(vin[2]);
      crp_in[1] = qrv_pkg::MV_W'(rot.z) * qrv_pkg::MV_W'(vin[1]);
      crp_in[2] = qrv_pkg::MV_W'(rot.z) * qrv_pkg::MV_W'(vin[0]);
      crp_in[3] = qrv_pkg::MV_W'(rot.x) * qrv_pkg::MV_W'(vin[2]);
      crp_in[4] = qrv_pkg::MV_W'(rot.x) * qrv_pkg::MV_W'(vin[1]);
      crp_in[5] = qrv_pkg::MV_W'(rot.y) * qrv_pkg::MV_W'(vin[0]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ff   <= sq_in;
         dot_ff  <= dot_in;
         crp_ff  <= crp_in;
         vec1_ff <= vin;
      end
   end

   // ---------------- stage 2: sums ----------------
   logic signed [qrv_pkg::A_W-1:0] a_ff;
   logic signed [qrv_pkg::A_W-1:0] a_in;
   logic signed [qrv_pkg::D_W-1:0] d2_ff;
   logic signed [qrv_pkg::D_W-1:0] d2_in;
   logic signed [qrv_pkg::C_W-1:0] cr_ff [3];
   logic signed [qrv_pkg::C_W-1:0] cr_in [3];
   qrv_pkg::vec_type               vec2_ff [3];

   always_comb begin
      a_in = qrv_pkg::A_W'(sq_ff[0]) - qrv_pkg::A_W'(sq_ff[1])
           - qrv_pkg::A_W'(sq_ff[2]) - qrv_pkg::A_W'(sq_ff[3]);
      d2_in = (qrv_pkg::D_W'(dot_ff[0]) + qrv_pkg::D_W'(dot_ff[1])
            + qrv_pkg::D_W'(dot_ff[2])) <<< 1;
      for (int i = 0; i < 3; i++) begin
         cr_in[i] = qrv_pkg::C_W'(crp_ff[2*i]) - qrv_pkg::C_W'(crp_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         a_ff    <= a_in;
         d2_ff   <= d2_in;
         cr_ff   <= cr_in;
         vec2_ff <= vec1_ff;
      end
   end

   // ---------------- stage 3: second multiply layer ----------------
   logic signed [qrv_pkg::W2_W-1:0] w2;
   logic signed [qrv_pkg::PA_W-1:0] pa_ff [3];
   logic signed [qrv_pkg::PA_W-1:0] pa_in [3];
   logic signed [qrv_pkg::PD_W-1:0] pd_ff [3];
   logic signed [qrv_pkg::PD_W-1:0] pd_in [3];
   logic signed [qrv_pkg::PC_W-1:0] pc_ff [3];
   logic signed [qrv_pkg::PC_W-1:0] pc_in [3];

   assign w2 = qrv_pkg::W2_W'(rot.w) <<< 1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa_in[i] = qrv_pkg::PA_W'(a_ff) * qrv_pkg::PA_W'(vec2_ff[i]);
         pd_in[i] = qrv_pkg::PD_W'(d2_ff) * qrv_pkg::PD_W'(qv[i]);
         pc_in[i] = qrv_pkg::PC_W'(w2) * qrv_pkg::PC_W'(cr_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         pa_ff <= pa_in;
         pd_ff <= pd_in;
         pc_ff <= pc_in;
      end
   end

   // ---------------- stage 4: sum plus rounding half ----------------
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = ACC_W'(pa_ff[i]) + ACC_W'(pd_ff[i]) + ACC_W'(pc_ff[i]) + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------- stage 5: rescale and clip ----------------
   qrv_pkg::out_type        out_ff [3];
   qrv_pkg::out_type        out_in [3];
   logic                    sat_ff;
   logic                    sat_in;
   logic signed [ACC_W-1:0] sh [3];
   logic [2:0]              hi;
   logic [2:0]              lo;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh[i] = acc_ff[i] >>> SHIFT;
         hi[i] = sh[i] > ACC_MAX;
         lo[i] = sh[i] < ACC_MIN;
         priority if (hi[i]) begin
            out_in[i] = qrv_pkg::OUT_W'(qrv_pkg::OUT_MAX);
         end else if (lo[i]) begin
            out_in[i] = qrv_pkg::OUT_W'(qrv_pkg::OUT_MIN);
         end else begin
            out_in[i] = sh[i][qrv_pkg::OUT_W-1:0];
         end
      end
      sat_in = |(hi | lo);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_chan.valid     = v_ff[NSTG-1];
   assign rsp_chan.out_x     = out_ff[0];
   assign rsp_chan.out_y     = out_ff[1];
   assign rsp_chan.out_z     = out_ff[2];
   assign rsp_chan.saturated = sat_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[0])
      else $error("accepted request not captured in first stage");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v_ff == '1) && !rsp_chan.ready)
      else $error("request refused while pipeline has room");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      v_ff[NSTG-2] && v_ff[NSTG-1] && !rsp_chan.ready |=> v_ff[NSTG-2])
      else $error("request lost behind stalled output");

   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      !req_chan.valid && !rsp_chan.ready |=> $countones(v_ff) == $past($countones(v_ff)))
      else $error("in-flight count changed with no transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
